FILE: rtl/core/psdf_pkg.sv
// Shared types and constants of the per-source duplicate filter.
package psdf_pkg;

    localparam int SOURCE_W       = 8;
    localparam int PACKET_ID_W    = 16;
    localparam int SRC_SPAN       = 2 ** SOURCE_W;
    localparam int NODE_COUNT_DEF = 256;
    localparam int ID_WIDTH_DEF   = 16;

    typedef enum logic [1:0] {
        MODE_RECEIVE = 2'd0,
        MODE_ACK     = 2'd1,
        MODE_QUERY   = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t                  mode;
        logic [SOURCE_W-1:0]    source_node;
        logic [PACKET_ID_W-1:0] packet_id;
    } req_t;

    typedef struct packed {
        logic accepted;
        logic ack_granted;
        logic duplicate_flag;
    } rsp_t;

endpackage

FILE: rtl/core/psdf_req_if.sv
// Request channel: valid/ready handshake carrying one filter request.
interface psdf_req_if;
    import psdf_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/psdf_rsp_if.sv
// Response channel: valid/ready handshake carrying one filter result.
interface psdf_rsp_if;
    import psdf_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/per_source_duplicate_filter.sv
// The table read lands in stage s1 (read), the result of the modify in the output register.
// Throughput: one request per cycle while the response side keeps up; the table
// read-modify-write of one entry memory port pair sets this, with write forwarding.
// Reset: asynchronous; afterwards a clearing pass writes NODE_COUNT entries, one per
// cycle, and req.ready stays low until the pass is done.
module per_source_duplicate_filter #(
    parameter int NODE_COUNT = psdf_pkg::NODE_COUNT_DEF,
    parameter int ID_WIDTH   = psdf_pkg::ID_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    psdf_req_if.sink   req,
    psdf_rsp_if.source rsp
);
    import psdf_pkg::*;

    localparam int IDX_W   = $clog2(NODE_COUNT);
    localparam int ENTRY_W = ID_WIDTH + 2;

    // Source number wrapped to the table size, one entry per possible source.
    function automatic logic [SRC_SPAN*IDX_W-1:0] build_mod_table();
        logic [SRC_SPAN*IDX_W-1:0] t;
        t = '0;
        for (int i = 0; i < SRC_SPAN; i++)
        begin
            t[i*IDX_W +: IDX_W] = IDX_W'(i % NODE_COUNT);
        end
        return t;
    endfunction

    localparam logic [SRC_SPAN*IDX_W-1:0] MOD_TABLE = build_mod_table();

    // Entry layout: {last id, duplicate flag, acked flag}
    logic                clr_busy_reg, clr_busy_next;
    logic [IDX_W-1:0]    clr_addr_reg, clr_addr_next;

    logic                s1_valid_reg, s1_valid_next;
    mode_t               s1_mode_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic [ID_WIDTH-1:0] s1_id_reg;

    logic                fwd_valid_reg, fwd_valid_next;
    logic [IDX_W-1:0]    fwd_idx_reg;
    logic [ENTRY_W-1:0]  fwd_entry_reg;

    logic                out_valid_reg, out_valid_next;
    rsp_t                out_data_reg;

    logic                accept;
    logic                s1_fire;
    logic [IDX_W-1:0]    req_idx;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [ENTRY_W-1:0]  cur_entry;
    logic [ID_WIDTH-1:0] cur_id;
    logic                cur_dup;
    logic                cur_ack;
    logic [ID_WIDTH-1:0] id_diff;
    logic                id_newer;

    logic                upd_we;
    logic [ENTRY_W-1:0]  upd_entry;
    rsp_t                upd_rsp;

    psdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (req_idx),
        .rdata (ram_rdata)
    );

    assign req_idx   = MOD_TABLE[int'(req.data.source_node)*IDX_W +: IDX_W];
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clr_busy_reg && (!s1_valid_reg || s1_fire);
    assign accept    = req.valid && req.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Take the last written entry when its index matches, in place of possibly stale RAM data.
    assign cur_entry = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_entry_reg
                                                                       : ram_rdata;
    assign cur_id    = cur_entry[ENTRY_W-1:2];
    assign cur_dup   = cur_entry[1];
    assign cur_ack   = cur_entry[0];
    assign id_diff   = s1_id_reg - cur_id;
    assign id_newer  = (id_diff != '0) && !id_diff[ID_WIDTH-1];

    always_comb
    begin
        upd_we                 = 1'b0;
        upd_entry              = cur_entry;
        upd_rsp.accepted       = 1'b0;
        upd_rsp.ack_granted    = 1'b0;
        upd_rsp.duplicate_flag = cur_dup;
        unique case (s1_mode_reg)
            MODE_RECEIVE:
            begin
                upd_we = 1'b1;
                if (id_newer)
                begin
                    upd_entry              = {s1_id_reg, 1'b0, 1'b0};
                    upd_rsp.accepted       = 1'b1;
                    upd_rsp.duplicate_flag = 1'b0;
                end
                else
                begin
                    upd_entry              = {cur_id, 1'b1, cur_ack};
                    upd_rsp.duplicate_flag = 1'b1;
                end
            end
            MODE_ACK:
            begin
                upd_we              = 1'b1;
                upd_entry           = {cur_id, cur_dup, 1'b1};
                upd_rsp.ack_granted = !cur_ack;
            end
            default:
            begin
                upd_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = clr_busy_reg || (s1_fire && upd_we);
        ram_waddr = clr_busy_reg ? clr_addr_reg : s1_idx_reg;
        ram_wdata = clr_busy_reg ? '0 : upd_entry;
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == IDX_W'(NODE_COUNT - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end

        priority if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        fwd_valid_next = fwd_valid_reg || (s1_fire && upd_we);

        priority if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= req.data.mode;
            s1_idx_reg  <= req_idx;
            s1_id_reg   <= ID_WIDTH'(req.data.packet_id);
        end
        // Hold the last written entry for the read issued on the same edge.
        if (s1_fire && upd_we)
        begin
            fwd_idx_reg   <= s1_idx_reg;
            fwd_entry_reg <= upd_entry;
        end
        if (s1_fire)
        begin
            out_data_reg <= upd_rsp;
        end
    end

endmodule

FILE: rtl/core/psdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
